FILE: src/pps_pkg.sv
// Shared types and codes for the preemptive priority scheduler.
// No dependencies; used by the scheduler top level and its port checker.
package pps_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Input command codes (carried in tuser).
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_ARRIVAL = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_ZERO_BURST = 2'd2
  } status_t;

  // One table entry: id in the top byte, then priority, then remaining burst.
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_CHK,
    S_SHIFT,
    S_ARR_STEP,
    S_ARR_PLACE,
    S_DONE
  } state_t;

endpackage

FILE: src/preemptive_priority_scheduler_unit.sv
// Preemptive priority scheduler top level: task table memory and its walk sequencer.
// Depends on pps_pkg (entry type, state and status codes).
// Checked by pps_checker, bound from its own file.
//
// One transaction in gives exactly one transaction out. The task table is a single
// write / single read memory of QUEUE_DEPTH entries, kept sorted by ascending
// priority number with ties in arrival order; entry 0 is the running task. All
// table work runs through one sequencer that touches one entry per cycle, so the
// cost of a transaction is set by the table walk:
//   tick on an empty table, rejected arrival          : no table walk
//   tick that leaves the head task running             : head read and written back
//   tick that completes the head task (N tasks queued) : each later task moved down one
//   accepted arrival landing at position P of N tasks : the N - P tasks from P on moved up
// The block takes a new transaction as soon as the sequencer is idle, even while
// the previous result still waits in the output register.
// tdata in: task_id[7:0], task_priority[15:8], task_burst[31:16]; tuser in: command.
// tdata out: finished_id[7:0], finish_time[39:8], arrival_status[41:40],
// running_id[49:42], running_valid[50], queued_count[55:51]; tuser out: finished.
module preemptive_priority_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // task_id, task_priority, task_burst
  input  logic [0:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // finished_id, finish_time, arrival_status,
                                      // running_id, running_valid, queued_count
  output logic [0:0]  m_axis_tuser    // finished
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Sequencer and scheduler state
  pps_pkg::state_t  state, state_next;
  logic [CW-1:0]    count, count_next;     // tasks held in the table
  logic [CW-1:0]    idx, idx_next;         // walk position
  logic [31:0]      cur_time, cur_time_next;
  logic [7:0]       head_id, head_id_next; // mirror of entry 0 id
  pps_pkg::entry_t  new_entry, new_entry_next;

  // Result being built for the current transaction
  logic             res_fin, res_fin_next;
  logic [7:0]       res_fid, res_fid_next;
  logic [31:0]      res_ftime, res_ftime_next;
  pps_pkg::status_t res_status, res_status_next;

  // Task table memory
  pps_pkg::entry_t  table_mem [QUEUE_DEPTH];
  pps_pkg::entry_t  rd_data;
  pps_pkg::entry_t  wr_data;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             mem_we;

  logic             out_load;
  logic [15:0]      dec_burst;
  logic             running_valid;
  logic [7:0]       running_id;
  logic [4:0]       queued_count;

  pps_pkg::entry_t  in_entry;

  assign in_entry.id    = s_axis_tdata[7:0];
  assign in_entry.prio  = s_axis_tdata[15:8];
  assign in_entry.burst = s_axis_tdata[31:16];

  assign dec_burst = rd_data.burst - 16'd1;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data <= table_mem[rd_addr];
  end

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    cur_time_next   = cur_time;
    head_id_next    = head_id;
    new_entry_next  = new_entry;
    res_fin_next    = res_fin;
    res_fid_next    = res_fid;
    res_ftime_next  = res_ftime;
    res_status_next = res_status;
    mem_we          = 1'b0;
    wr_addr         = '0;
    wr_data         = rd_data;
    rd_addr         = '0;
    out_load        = 1'b0;
    s_axis_tready   = 1'b0;

    case (state)
      pps_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        // Prefetch the head for a tick, the tail entry for an arrival
        if (s_axis_tuser[0] == pps_pkg::CMD_ARRIVAL) begin
          rd_addr = AW'(count - CW'(1));
        end
        if (s_axis_tvalid) begin
          res_fin_next    = 1'b0;
          res_fid_next    = 8'd0;
          res_ftime_next  = 32'd0;
          res_status_next = pps_pkg::ST_OK;
          if (s_axis_tuser[0] == pps_pkg::CMD_TICK) begin
            cur_time_next = cur_time + 32'd1;
            state_next    = (count == '0) ? pps_pkg::S_DONE : pps_pkg::S_TICK_CHK;
          end else if (in_entry.burst == 16'd0) begin
            res_status_next = pps_pkg::ST_ZERO_BURST;
            state_next      = pps_pkg::S_DONE;
          end else if (count >= CW'(QUEUE_DEPTH)) begin
            res_status_next = pps_pkg::ST_FULL;
            state_next      = pps_pkg::S_DONE;
          end else begin
            new_entry_next = in_entry;
            idx_next       = count;
            state_next     = (count == '0) ? pps_pkg::S_ARR_PLACE : pps_pkg::S_ARR_STEP;
          end
        end
      end

      pps_pkg::S_TICK_CHK: begin
        // rd_data holds the head entry
        rd_addr = AW'(1);
        if (dec_burst == 16'd0) begin
          res_fin_next   = 1'b1;
          res_fid_next   = rd_data.id;
          res_ftime_next = cur_time;
          if (count == CW'(1)) begin
            count_next = count - CW'(1);
            state_next = pps_pkg::S_DONE;
          end else begin
            idx_next   = CW'(1);
            state_next = pps_pkg::S_SHIFT;
          end
        end else begin
          mem_we        = 1'b1;
          wr_addr       = '0;
          wr_data.id    = rd_data.id;
          wr_data.prio  = rd_data.prio;
          wr_data.burst = dec_burst;
          head_id_next  = rd_data.id;
          state_next    = pps_pkg::S_DONE;
        end
      end

      pps_pkg::S_SHIFT: begin
        // Move entry idx down to idx-1, fetch the next one
        mem_we  = 1'b1;
        wr_addr = AW'(idx - CW'(1));
        wr_data = rd_data;
        rd_addr = AW'(idx + CW'(1));
        if (idx == CW'(1)) begin
          head_id_next = rd_data.id;
        end
        if ((idx + CW'(1)) < count) begin
          idx_next = idx + CW'(1);
        end else begin
          count_next = count - CW'(1);
          state_next = pps_pkg::S_DONE;
        end
      end

      pps_pkg::S_ARR_STEP: begin
        // rd_data holds entry idx-1; open a slot or drop the new task into idx
        rd_addr = AW'(idx - CW'(2));
        mem_we  = 1'b1;
        wr_addr = AW'(idx);
        if (rd_data.prio > new_entry.prio) begin
          wr_data  = rd_data;
          idx_next = idx - CW'(1);
          if (idx == CW'(1)) begin
            state_next = pps_pkg::S_ARR_PLACE;
          end
        end else begin
          wr_data    = new_entry;
          count_next = count + CW'(1);
          state_next = pps_pkg::S_DONE;
        end
      end

      pps_pkg::S_ARR_PLACE: begin
        mem_we     = 1'b1;
        wr_addr    = AW'(idx);
        wr_data    = new_entry;
        count_next = count + CW'(1);
        if (idx == '0) begin
          head_id_next = new_entry.id;
        end
        state_next = pps_pkg::S_DONE;
      end

      pps_pkg::S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = pps_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = pps_pkg::S_IDLE;
      end
    endcase
  end

  assign running_valid = (count != '0);
  assign running_id    = running_valid ? head_id : 8'd0;
  assign queued_count  = 5'(count);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pps_pkg::S_IDLE;
      count         <= '0;
      cur_time      <= 32'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cur_time <= cur_time_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    head_id    <= head_id_next;
    new_entry  <= new_entry_next;
    res_fin    <= res_fin_next;
    res_fid    <= res_fid_next;
    res_ftime  <= res_ftime_next;
    res_status <= res_status_next;
    if (out_load) begin
      m_axis_tuser <= res_fin;
      m_axis_tdata <= {queued_count, running_valid, running_id, res_status,
                       res_ftime, res_fid};
    end
  end

endmodule

FILE: src/pps_checker.sv
// Port-level checker for the preemptive priority scheduler, bound to its top level.
// Depends on pps_pkg (status codes) and preemptive_priority_scheduler_unit.
module pps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A completion only comes from a tick, never with an arrival status
  a_fin_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[41:40] == pps_pkg::ST_OK)
    else $error("completion reported with arrival status");

  // An empty table shows no running task
  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[50] |-> m_axis_tdata[49:42] == 8'd0)
    else $error("running id without running task");

  // Reset empties the output stage
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Without a completion, the finished id and finish time fields are zero
  a_fin_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[39:8] == 32'd0)
    else $error("completion fields set without completion");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);

FILE: tb/tb_preemptive_priority_scheduler_unit.sv
// Self-checking testbench for the preemptive priority scheduler unit.
// Depends on pps_pkg and preemptive_priority_scheduler_unit; reads no files.
// Directed table first, then random ticks and arrivals checked against a local task table.
module tb_preemptive_priority_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 800;

  // One result transaction, unpacked from the master side.
  typedef struct packed {
    logic             finished;
    logic [7:0]       fin_id;
    logic [31:0]      fin_time;
    pps_pkg::status_t status;
    logic [7:0]       run_id;
    logic             run_valid;
    logic [4:0]       count;
  } sched_result_t;

  // One directed row. Use the typed-in result when has_exp is set, else predict it.
  typedef struct packed {
    logic          cmd;
    logic [7:0]    id;
    logic [7:0]    prio;
    logic [15:0]   burst;
    logic          has_exp;
    sched_result_t exp;
  } stim_row_t;

  localparam sched_result_t NO_RESULT = '0;

  // Directed walk: tick on an empty table, zero burst, field extremes, preemption,
  // completion, equal priority, fill to full, full rejection, zero burst checked
  // ahead of the full check, then ticks on the full table.
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{pps_pkg::CMD_TICK,    8'hA5, 8'h5A, 16'hFFFF, 1'b1,
      '{1'b0, 8'h00, 32'd0, pps_pkg::ST_OK, 8'h00, 1'b0, 5'd0}},
    '{pps_pkg::CMD_ARRIVAL, 8'h42, 8'h10, 16'h0000, 1'b1,
      '{1'b0, 8'h00, 32'd0, pps_pkg::ST_ZERO_BURST, 8'h00, 1'b0, 5'd0}},
    '{pps_pkg::CMD_ARRIVAL, 8'hFF, 8'hFF, 16'hFFFF, 1'b1,
      '{1'b0, 8'h00, 32'd0, pps_pkg::ST_OK, 8'hFF, 1'b1, 5'd1}},
    '{pps_pkg::CMD_ARRIVAL, 8'h00, 8'h00, 16'h0001, 1'b1,
      '{1'b0, 8'h00, 32'd0, pps_pkg::ST_OK, 8'h00, 1'b1, 5'd2}},
    '{pps_pkg::CMD_TICK,    8'h00, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 8'h00, 32'd2, pps_pkg::ST_OK, 8'hFF, 1'b1, 5'd1}},
    '{pps_pkg::CMD_ARRIVAL, 8'h11, 8'hFF, 16'h0002, 1'b1,
      '{1'b0, 8'h00, 32'd0, pps_pkg::ST_OK, 8'hFF, 1'b1, 5'd2}},
    '{pps_pkg::CMD_ARRIVAL, 8'h20, 8'h80, 16'd2, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h21, 8'h40, 16'd1, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h22, 8'hC0, 16'd3, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h23, 8'h40, 16'd1, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h24, 8'h01, 16'd2, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h25, 8'h80, 16'd1, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h26, 8'h20, 16'd2, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h27, 8'hFE, 16'd1, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h28, 8'h40, 16'd2, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h29, 8'h02, 16'd1, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h2A, 8'h60, 16'd3, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h2B, 8'h01, 16'd1, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h2C, 8'h90, 16'd2, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h2D, 8'h10, 16'd1, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_ARRIVAL, 8'h77, 8'h00, 16'h0005, 1'b1,
      '{1'b0, 8'h00, 32'd0, pps_pkg::ST_FULL, 8'h24, 1'b1, 5'd16}},
    '{pps_pkg::CMD_ARRIVAL, 8'h78, 8'h00, 16'h0000, 1'b1,
      '{1'b0, 8'h00, 32'd0, pps_pkg::ST_ZERO_BURST, 8'h24, 1'b1, 5'd16}},
    '{pps_pkg::CMD_TICK,    8'hFF, 8'hFF, 16'hFFFF, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_TICK,    8'h00, 8'h00, 16'h0000, 1'b0, NO_RESULT},
    '{pps_pkg::CMD_TICK,    8'h5A, 8'hA5, 16'h8000, 1'b0, NO_RESULT}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  // Local copy of the scheduler state.
  pps_pkg::entry_t sched_table [TABLE_DEPTH];
  int unsigned     sched_count = 0;
  logic [31:0]     sched_clock = '0;

  sched_result_t pending_results [$];
  int unsigned   fail_count = 0;
  bit            steady = 1'b0;   // set: neither side idles

  preemptive_priority_scheduler_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("[preemptive_priority_scheduler_unit] ERROR");
    $finish;
  end

  // Apply one tick or arrival to the local table and return what the block must report.
  function automatic sched_result_t schedule_step(input logic cmd, input logic [7:0] id,
                                                  input logic [7:0] prio,
                                                  input logic [15:0] burst);
    sched_result_t r;
    int unsigned   pos;
    int unsigned   i;
    r.finished  = 1'b0;
    r.fin_id    = '0;
    r.fin_time  = '0;
    r.status    = pps_pkg::ST_OK;
    if (cmd == pps_pkg::CMD_TICK) begin
      // Time always advances; only a non-empty table loses service.
      sched_clock = sched_clock + 32'd1;
      if (sched_count != 0) begin
        sched_table[0].burst = sched_table[0].burst - 16'd1;
        if (sched_table[0].burst == 16'd0) begin
          r.finished = 1'b1;
          r.fin_id   = sched_table[0].id;
          r.fin_time = sched_clock;
          for (i = 0; i + 1 < sched_count; i++) sched_table[i] = sched_table[i + 1];
          sched_count--;
        end
      end
    end else if (burst == 16'd0) begin
      r.status = pps_pkg::ST_ZERO_BURST;
    end else if (sched_count >= TABLE_DEPTH) begin
      r.status = pps_pkg::ST_FULL;
    end else begin
      // Skip every entry of equal or better priority, then open a slot.
      pos = 0;
      while (pos < sched_count && sched_table[pos].prio <= prio) pos++;
      for (i = sched_count; i > pos; i--) sched_table[i] = sched_table[i - 1];
      sched_table[pos] = '{id: id, prio: prio, burst: burst};
      sched_count++;
    end
    r.run_valid = (sched_count != 0);
    r.run_id    = r.run_valid ? sched_table[0].id : 8'h00;
    r.count     = sched_count[4:0];
    return r;
  endfunction

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  // Offer one transaction, hold it until accepted, then queue its expected result.
  task automatic send_item(input logic cmd, input logic [7:0] id, input logic [7:0] prio,
                           input logic [15:0] burst, input logic has_exp,
                           input sched_result_t typed_exp);
    sched_result_t predicted;
    if (!steady) begin
      while ($urandom_range(0, 99) < 26) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {burst, prio, id};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = schedule_step(cmd, id, prio, burst);
    pending_results.push_back(has_exp ? typed_exp : predicted);
  endtask

  // Result side: stall at random except during the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.finished  = m_axis_tuser[0];
      got.fin_id    = m_axis_tdata[7:0];
      got.fin_time  = m_axis_tdata[39:8];
      got.status    = pps_pkg::status_t'(m_axis_tdata[41:40]);
      got.run_id    = m_axis_tdata[49:42];
      got.run_valid = m_axis_tdata[50];
      got.count     = m_axis_tdata[55:51];
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("finished", want.finished, got.finished);
        check_field("finished_id", want.fin_id, got.fin_id);
        check_field("finish_time", want.fin_time, got.fin_time);
        check_field("arrival_status", want.status, got.status);
        check_field("running_id", want.run_id, got.run_id);
        check_field("running_valid", want.run_valid, got.run_valid);
        check_field("queued_count", want.count, got.count);
      end
    end
  end

  initial begin
    logic        cmd;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    int unsigned roll;
    int unsigned heavy_left;
    int unsigned guard;

    heavy_left = 4;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[k]) begin
      send_item(DIRECTED_ROWS[k].cmd, DIRECTED_ROWS[k].id, DIRECTED_ROWS[k].prio,
                DIRECTED_ROWS[k].burst, DIRECTED_ROWS[k].has_exp, DIRECTED_ROWS[k].exp);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Run one stretch with both sides at full rate.
      steady = (n >= 300 && n < 450);
      // Ticks carry random noise in the fields they ignore.
      id    = 8'($urandom);
      prio  = 8'($urandom);
      burst = 16'($urandom);
      // Lean toward ticks once the table fills, so tasks keep completing.
      roll = $urandom_range(0, 99);
      cmd  = (roll < (sched_count < 10 ? 55 : 30)) ? pps_pkg::CMD_ARRIVAL
                                                   : pps_pkg::CMD_TICK;
      if (cmd == pps_pkg::CMD_ARRIVAL) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          burst = 16'd0;
        end else if (roll < 7 && heavy_left != 0) begin
          // Few long tasks, parked at the lowest priority so they never block.
          heavy_left--;
          prio  = 8'hFF;
          burst = 16'($urandom_range(1, 65535));
        end else begin
          prio  = 8'($urandom_range(0, 254));
          burst = 16'($urandom_range(1, 6));
        end
      end
      send_item(cmd, id, prio, burst, 1'b0, NO_RESULT);
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    // Drain, then keep watching for stray results.
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("[preemptive_priority_scheduler_unit] OK");
    end else begin
      $display("[preemptive_priority_scheduler_unit] ERROR");
    end
    $finish;
  end

endmodule
